>>> hw/rtl/iib_pkg.sv
// ============================================================================
// iib_pkg - shared types and constants for the integral image builder
// Field widths, register indexes, queue depths and the back-end status bundle.
// ============================================================================
`default_nettype none

package iib_pkg;

    // Fixed field widths
    localparam int PIX_W     = 8;    // input pixel port
    localparam int OUT_W     = 28;   // integral value port
    localparam int CFG_W     = 11;   // size registers
    localparam int CFG_IDX_W = 1;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    // Queue depths
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Back end handshake toward the queues
    typedef struct packed {
        logic pop;    // take one command from the command queue
        logic push;   // one result into the result queue
        logic busy;   // line store clear in progress
    } t_back_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/iib_ram.sv
// ============================================================================
// iib_ram - generic single-write, single-read RAM
// One write port, one read port, registered read data (old data on collision).
// ============================================================================
`default_nettype none

module iib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/iib_fifo.sv
// ============================================================================
// iib_fifo - small register queue
// Push and pop in the same cycle are allowed; callers never push when full.
// ============================================================================
`default_nettype none

module iib_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic [CNTW-1:0]  o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0]  r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> hw/rtl/iib_front.sv
// ============================================================================
// iib_front - pixel intake and position tracking
// Holds the size registers, column/row counters and the row running sum;
// turns each accepted pixel into a command word for the back end.
// ============================================================================
`default_nettype none

module iib_front #(
    parameter int MAX_WIDTH  = iib_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iib_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = iib_pkg::DEF_PIXEL_BITS,
    localparam int CMD_W     = $clog2(MAX_WIDTH) + 2 + iib_pkg::OUT_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [iib_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [iib_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    input  logic [iib_pkg::PIX_W-1:0]    i_pixel_value,
    input  logic                         i_cmd_full,
    input  logic                         i_busy,
    output logic                         o_stall,
    output logic                         o_push,
    output logic [CMD_W-1:0]             o_cmd
);

    import iib_pkg::*;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int PIX_USE = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
    localparam int RS_W    = PIX_USE + CW;
    localparam int WC_W    = ((CFG_W > CW + 1) ? CFG_W : CW + 1) + 1;
    localparam int HC_W    = ((CFG_W > RW + 1) ? CFG_W : RW + 1) + 1;

    logic [CFG_W-1:0] r_width, r_height;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [RS_W-1:0]  r_row_sum;

    logic [WC_W-1:0]  w_ext, w_lim, col_inc;
    logic [HC_W-1:0]  h_ext, h_lim, row_inc;
    logic             row_end, frame_end, accept;
    logic [RS_W-1:0]  rs_new;

    // zero reads as one, oversize saturates
    always_comb begin
        w_ext = WC_W'(r_width);
        h_ext = HC_W'(r_height);
        if (w_ext == '0) begin
            w_lim = WC_W'(1);
        end else if (w_ext > WC_W'(MAX_WIDTH)) begin
            w_lim = WC_W'(MAX_WIDTH);
        end else begin
            w_lim = w_ext;
        end
        if (h_ext == '0) begin
            h_lim = HC_W'(1);
        end else if (h_ext > HC_W'(MAX_HEIGHT)) begin
            h_lim = HC_W'(MAX_HEIGHT);
        end else begin
            h_lim = h_ext;
        end
    end

    assign col_inc   = WC_W'(r_col) + WC_W'(1);
    assign row_inc   = HC_W'(r_row) + HC_W'(1);
    assign row_end   = (col_inc >= w_lim);
    assign frame_end = row_end && (row_inc >= h_lim);
    assign rs_new    = r_row_sum + RS_W'(i_pixel_value[PIX_USE-1:0]);

    assign o_stall = i_busy || i_cmd_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = accept;
    assign o_cmd   = {r_col, (r_row == '0), frame_end, OUT_W'(rs_new)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= CFG_SIZE_RESET;
            r_height  <= CFG_SIZE_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_row_sum <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (row_end) begin
                    r_col     <= '0;
                    r_row_sum <= '0;
                    r_row     <= frame_end ? '0 : RW'(row_inc);
                end else begin
                    r_col     <= CW'(col_inc);
                    r_row_sum <= rs_new;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/iib_back.sv
// ============================================================================
// iib_back - line store update and integral sum
// Pops commands, reads the value above from the line store, adds the row sum,
// writes the result back and hands it to the result queue. Clears the store
// after reset.
// ============================================================================
`default_nettype none

module iib_back #(
    parameter int MAX_WIDTH = iib_pkg::DEF_MAX_WIDTH,
    parameter int RES_DEPTH = iib_pkg::RES_DEPTH,
    localparam int CMD_W    = $clog2(MAX_WIDTH) + 2 + iib_pkg::OUT_W,
    localparam int RCW      = $clog2(RES_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic                    i_cmd_avail,
    input  logic [RCW-1:0]          i_res_count,
    output iib_pkg::t_back_ctl      o_ctl,
    output logic [iib_pkg::OUT_W:0] o_result
);

    import iib_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CRW = RCW + 1;

    logic [CW-1:0]    cmd_col;
    logic             cmd_first, cmd_fe;
    logic [OUT_W-1:0] cmd_rs;

    logic             r_busy;
    logic [CW-1:0]    r_clr_addr;
    logic             r_s1_valid;
    logic [CW-1:0]    r_s1_col;
    logic             r_s1_first, r_s1_fe, r_s1_fwd;
    logic [OUT_W-1:0] r_s1_rs, r_s1_fwd_data;

    logic [OUT_W-1:0] ram_q, above, integ;
    logic             credit, pop;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    logic [OUT_W-1:0] wr_data;

    assign {cmd_col, cmd_first, cmd_fe, cmd_rs} = i_cmd;

    // room for this command once everything in flight has landed
    assign credit = (CRW'(i_res_count) + CRW'(r_s1_valid)) < CRW'(RES_DEPTH);
    assign pop    = i_cmd_avail && !r_busy && credit;

    // previous command wrote the same entry while this one was read: take its value directly
    always_comb begin
        if (r_s1_first) begin
            above = '0;
        end else if (r_s1_fwd) begin
            above = r_s1_fwd_data;
        end else begin
            above = ram_q;
        end
    end

    assign integ   = r_s1_rs + above;
    assign wr_en   = r_busy || r_s1_valid;
    assign wr_addr = r_busy ? r_clr_addr : r_s1_col;
    assign wr_data = r_busy ? '0 : integ;

    iib_ram #(
        .WIDTH (OUT_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (pop),
        .i_rd_addr (cmd_col),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (r_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            r_s1_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_col      <= cmd_col;
            r_s1_first    <= cmd_first;
            r_s1_fe       <= cmd_fe;
            r_s1_rs       <= cmd_rs;
            r_s1_fwd      <= r_s1_valid && (r_s1_col == cmd_col);
            r_s1_fwd_data <= integ;
        end
    end

    assign o_ctl.pop  = pop;
    assign o_ctl.push = r_s1_valid;
    assign o_ctl.busy = r_busy;
    assign o_result   = {integ, r_s1_fe};

endmodule

`default_nettype wire

>>> hw/rtl/integral_image_builder_unit.sv
// ============================================================================
// integral_image_builder_unit - streaming summed-area table builder
// Takes grayscale pixels in raster order and returns, for each one, the sum of
// all pixels at or above and at or left of it in the current frame.
// ============================================================================
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  pixel    | in        | i_valid / o_stall  | i_pixel_value[7:0]
//  result   | out       | o_valid / i_stall  | o_integral_value[27:0], o_frame_end
//  config   | in        | i_cfg_wr_en        | i_cfg_index, i_cfg_data[10:0]
//
//  One pixel per clock sustained while neither side stalls; a word reaches
//  the output after the command queue write at the accept edge, the line
//  store read and the result queue write.
//  The line store read-modify-write in the back end sets that rate.
//  After reset the line store is cleared, one entry per cycle, with o_stall
//  high until all MAX_WIDTH entries are written. Config writes are taken during that time.
//  Input and output stall independently; the command and result queues hold
//  up to four words each.
//
`default_nettype none

module integral_image_builder_unit #(
    parameter int MAX_WIDTH  = iib_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iib_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = iib_pkg::DEF_PIXEL_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [iib_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [iib_pkg::CFG_W-1:0]     i_cfg_data,
    // pixel input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [iib_pkg::PIX_W-1:0]     i_pixel_value,
    // result output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [iib_pkg::OUT_W-1:0]     o_integral_value,
    output logic                          o_frame_end
);

    import iib_pkg::*;

    localparam int CMD_W = $clog2(MAX_WIDTH) + 2 + OUT_W;
    localparam int CCW   = $clog2(CMD_DEPTH + 1);
    localparam int RCW   = $clog2(RES_DEPTH + 1);

    // front -> command queue
    logic             w_cmd_push;
    logic [CMD_W-1:0] w_cmd_in, w_cmd_out;
    logic [CCW-1:0]   w_cmd_cnt;
    logic             w_cmd_full;

    // back end
    t_back_ctl        w_ctl;
    logic [OUT_W:0]   w_res_in, w_res_out;
    logic [RCW-1:0]   w_res_cnt;
    logic             w_res_pop;

    assign w_cmd_full = (w_cmd_cnt == CCW'(CMD_DEPTH));

    iib_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_pixel_value (i_pixel_value),
        .i_cmd_full    (w_cmd_full),
        .i_busy        (w_ctl.busy),
        .o_stall       (o_stall),
        .o_push        (w_cmd_push),
        .o_cmd         (w_cmd_in)
    );

    // command queue: position, first-row flag, frame end, row sum
    iib_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_ctl.pop),
        .o_data  (w_cmd_out),
        .o_count (w_cmd_cnt)
    );

    iib_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_avail (w_cmd_cnt != '0),
        .i_res_count (w_res_cnt),
        .o_ctl       (w_ctl),
        .o_result    (w_res_in)
    );

    // result queue doubles as the output register stage
    iib_fifo #(
        .WIDTH (OUT_W + 1),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ctl.push),
        .i_data  (w_res_in),
        .i_pop   (w_res_pop),
        .o_data  (w_res_out),
        .o_count (w_res_cnt)
    );

    assign o_valid          = (w_res_cnt != '0);
    assign w_res_pop        = o_valid && !i_stall;
    assign o_integral_value = w_res_out[OUT_W:1];
    assign o_frame_end      = w_res_out[0];

`ifndef ASSERT_OFF
    // line store clear runs once after reset and never restarts
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ctl.busy |=> !w_ctl.busy)
        else $error("line store clear restarted");

    // back end never pops an empty command queue
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |-> (w_cmd_cnt != '0))
        else $error("command pop from empty queue");

    // result credit keeps the result queue from overflowing
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |-> ((w_res_cnt != RCW'(RES_DEPTH)) || w_res_pop))
        else $error("result queue overflow");

    // command queue count tracks a lone push
    a_cmd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_push && !w_ctl.pop) |=> (w_cmd_cnt == $past(w_cmd_cnt) + 1'b1))
        else $error("command queue count mismatch");
`endif

endmodule

`default_nettype wire
